FILE: hdl/imh_pkg.sv
package imh_pkg;

    localparam int CAPACITY = 256;
    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int VERT_W   = 8;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 9;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [VERT_W-1:0] vert_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_SETKEY  = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADVERT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_PMAP,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD,
        S_EX_MOVE,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_PM_FIX,
        S_DONE
    } fsm_t;

    // command from controller to datapath
    typedef struct packed {
        fsm_t state;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic reject;
        logic is_insert;
        logic is_extract;
        logic is_setkey;
        logic go_up;
        logic up_more;
        logic dn_more;
        logic dn_have_right;
        logic ex_move;
    } stat_t;

endpackage

FILE: hdl/imh_if.sv
interface imh_req_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [imh_pkg::VERT_W-1:0] vertex;
    logic [imh_pkg::KEY_W-1:0]  key;
    modport source (output valid, req_type, vertex, key, input ready);
    modport sink   (input valid, req_type, vertex, key, output ready);
endinterface

interface imh_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [imh_pkg::VERT_W-1:0] min_vertex;
    logic                    vertex_present;
    logic [imh_pkg::CNT_W-1:0]  entry_count;
    modport source (output valid, status, min_vertex, vertex_present, entry_count,
                    input ready);
    modport sink   (input valid, status, min_vertex, vertex_present, entry_count,
                    output ready);
endinterface

interface imh_cfg_if;
    logic                   valid;
    logic                   ready;
    logic [imh_pkg::CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/imh_ctrl.sv
module imh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_free,
    input  imh_pkg::stat_t  st,
    output imh_pkg::cmd_t   cmd
);
    imh_pkg::fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= imh_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.state  = state_reg;
        unique case (state_reg)
            imh_pkg::S_CLEAR:   if (st.clear_done) state_next = imh_pkg::S_IDLE;
            imh_pkg::S_IDLE:    if (in_fire) state_next = imh_pkg::S_CHECK;
            imh_pkg::S_CHECK:
            begin
                priority if (st.reject)     state_next = imh_pkg::S_DONE;
                else if (st.is_insert)      state_next = imh_pkg::S_PMAP;
                else if (st.is_extract)     state_next = imh_pkg::S_EX_RD;
                else if (st.is_setkey)      state_next = imh_pkg::S_PMAP;
                else                        state_next = imh_pkg::S_DONE;
            end
            imh_pkg::S_PMAP:    state_next = imh_pkg::S_UP_RD;
            imh_pkg::S_UP_RD:   state_next = st.go_up ? imh_pkg::S_UP_CMP : imh_pkg::S_DONE;
            imh_pkg::S_UP_CMP:  state_next = st.up_more ? imh_pkg::S_UP_RD : imh_pkg::S_DONE;
            imh_pkg::S_EX_RD:   state_next = st.ex_move ? imh_pkg::S_EX_MOVE : imh_pkg::S_DONE;
            imh_pkg::S_EX_MOVE: state_next = imh_pkg::S_DN_RD;
            imh_pkg::S_DN_RD:
                state_next = st.dn_more ? imh_pkg::S_DN_RD2 : imh_pkg::S_DONE;
            imh_pkg::S_DN_RD2:  state_next = imh_pkg::S_DN_CMP;
            imh_pkg::S_DN_CMP:  state_next = st.dn_more ? imh_pkg::S_PM_FIX : imh_pkg::S_DONE;
            imh_pkg::S_PM_FIX:  state_next = imh_pkg::S_DN_RD;
            imh_pkg::S_DONE:    if (out_free) state_next = imh_pkg::S_IDLE;
            default:            state_next = imh_pkg::S_IDLE;
        endcase
    end
endmodule

FILE: hdl/imh_datapath.sv
module imh_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic [1:0]                in_req,
    input  logic [imh_pkg::VERT_W-1:0] in_vertex,
    input  logic [imh_pkg::KEY_W-1:0] in_key,
    input  logic [imh_pkg::CNT_W-1:0] limit,
    input  imh_pkg::cmd_t             cmd,
    output imh_pkg::stat_t            st,
    output logic [1:0]                res_status,
    output logic [imh_pkg::VERT_W-1:0] res_min,
    output logic                      res_present,
    output logic [imh_pkg::CNT_W-1:0] res_count
);
    localparam int SW = imh_pkg::SLOT_W;
    localparam int VW = imh_pkg::VERT_W;
    localparam int KW = imh_pkg::KEY_W;

    // heap memory: one entry = key and vertex; slot 0 unused
    logic [KW+VW-1:0] heap_mem [0:imh_pkg::CAPACITY];
    // position map memory, cleared by a pass after reset
    logic [SW-1:0]    pos_mem  [0:imh_pkg::CAPACITY-1];

    logic [1:0]    req_reg;
    logic [VW-1:0] vtx_reg;
    logic [KW-1:0] key_reg;
    logic [SW-1:0] cnt_reg;
    logic [1:0]    status_reg;
    logic [VW-1:0] min_reg;
    logic          present_reg;
    logic [SW-1:0] cur_reg;       // moving slot
    logic [KW-1:0] ckey_reg;      // key of moving entry
    logic [VW-1:0] cvtx_reg;      // vertex of moving entry
    logic [KW+VW-1:0] rd_reg;     // registered heap read
    logic [KW+VW-1:0] lch_reg;    // left child
    logic [VW-1:0] clr_reg;
    logic          clr_last_reg;

    logic [SW-1:0] hrd_addr;
    logic [VW-1:0] prd_addr;
    logic [SW-1:0] prd_data_reg;
    logic          hwe;
    logic [SW-1:0] hwa;
    logic [KW+VW-1:0] hwd;
    logic          pwe;
    logic [VW-1:0] pwa;
    logic [SW-1:0] pwd;

    logic [SW-1:0] lim_eff;
    logic          vtx_oor;
    logic [SW-1:0] parent;
    logic [SW:0]   lchild;
    logic [SW:0]   rchild;
    logic [KW-1:0] lkey;
    logic [KW-1:0] rkey;
    logic          pick_l;
    logic          pick_r;

    always_comb
    begin
        if (limit == '0)
            lim_eff = SW'(1);
        else if (32'(limit) > imh_pkg::CAPACITY)
            lim_eff = SW'(imh_pkg::CAPACITY);
        else
            lim_eff = SW'(limit);
    end

    assign vtx_oor = (SW'(vtx_reg) >= lim_eff);
    assign parent  = cur_reg >> 1;
    assign lchild  = {cur_reg, 1'b0};
    assign rchild  = {cur_reg, 1'b1};
    assign lkey    = lch_reg[KW+VW-1:VW];
    assign rkey    = rd_reg[KW+VW-1:VW];
    assign pick_l  = (lchild <= (SW+1)'(cnt_reg)) && (lkey < ckey_reg);
    assign pick_r  = (rchild <= (SW+1)'(cnt_reg)) &&
                     (rkey < (pick_l ? lkey : ckey_reg));

    // status toward controller
    always_comb
    begin
        st = '0;
        st.clear_done = clr_last_reg;
        st.is_insert  = (req_reg == imh_pkg::REQ_INSERT);
        st.is_extract = (req_reg == imh_pkg::REQ_EXTRACT);
        st.is_setkey  = (req_reg == imh_pkg::REQ_SETKEY);
        unique case (req_reg)
            imh_pkg::REQ_INSERT:
                st.reject = vtx_oor || (cnt_reg >= lim_eff) || (prd_data_reg != '0);
            imh_pkg::REQ_EXTRACT: st.reject = (cnt_reg == '0);
            imh_pkg::REQ_SETKEY:  st.reject = vtx_oor || (prd_data_reg == '0);
            default:              st.reject = 1'b0;
        endcase
        st.go_up   = (cur_reg > SW'(1));
        st.up_more = (ckey_reg < rkey);
        st.ex_move = (cnt_reg != '0);
        st.dn_more = (cmd.state == imh_pkg::S_DN_RD) ? (lchild <= (SW+1)'(cnt_reg))
                                                     : (pick_l || pick_r);
        st.dn_have_right = (rchild <= (SW+1)'(cnt_reg));
    end

    // memory address and write selection
    always_comb
    begin
        hrd_addr = cur_reg;
        prd_addr = vtx_reg;
        hwe = 1'b0; hwa = cur_reg; hwd = {ckey_reg, cvtx_reg};
        pwe = 1'b0; pwa = cvtx_reg; pwd = cur_reg;
        unique case (cmd.state)
            imh_pkg::S_IDLE:    prd_addr = in_vertex;
            imh_pkg::S_CLEAR:
            begin
                pwe = 1'b1; pwa = clr_reg; pwd = '0;
            end
            imh_pkg::S_CHECK:   hrd_addr = SW'(1);
            imh_pkg::S_PMAP:
            begin
                pwe = 1'b1; pwa = cvtx_reg; pwd = cur_reg;
                hwe = 1'b1;
            end
            imh_pkg::S_UP_RD:   hrd_addr = parent;
            imh_pkg::S_UP_CMP:
            begin
                if (ckey_reg < rkey)
                begin
                    // parent moves down, moving entry goes up
                    hwe = 1'b1; hwa = cur_reg; hwd = rd_reg;
                    pwe = 1'b1; pwa = rd_reg[VW-1:0]; pwd = cur_reg;
                end
            end
            imh_pkg::S_EX_RD:
            begin
                // count is already decremented, the last entry sits one above it
                hrd_addr = cnt_reg + SW'(1);
                pwe = 1'b1; pwa = rd_reg[VW-1:0]; pwd = '0;
            end
            imh_pkg::S_EX_MOVE: ;
            imh_pkg::S_DN_RD:   hrd_addr = lchild[SW-1:0];
            imh_pkg::S_DN_RD2:  hrd_addr = rchild[SW-1:0];
            imh_pkg::S_DN_CMP:
            begin
                if (pick_l || pick_r)
                begin
                    hwe = 1'b1; hwa = cur_reg;
                    hwd = pick_r ? rd_reg : lch_reg;
                    pwe = 1'b1; pwa = pick_r ? rd_reg[VW-1:0] : lch_reg[VW-1:0];
                    pwd = cur_reg;
                end
                else
                begin
                    hwe = 1'b1;
                    pwe = 1'b1;
                end
            end
            imh_pkg::S_PM_FIX:  ;
            imh_pkg::S_DONE:    ;
            default:            ;
        endcase
        // final placement of a sift-up or sift-down entry when it stops
        if (cmd.state == imh_pkg::S_UP_CMP && !(ckey_reg < rkey))
        begin
            hwe = 1'b1; pwe = 1'b1;
        end
        if (cmd.state == imh_pkg::S_UP_RD && !(cur_reg > SW'(1)))
        begin
            hwe = 1'b1; pwe = 1'b1;
        end
        if (cmd.state == imh_pkg::S_DN_RD && !(lchild <= (SW+1)'(cnt_reg)))
        begin
            hwe = 1'b1; pwe = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
            heap_mem[hwa] <= hwd;
        rd_reg <= heap_mem[hrd_addr];
        if (pwe)
            pos_mem[pwa] <= pwd;
        prd_data_reg <= pos_mem[prd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            clr_reg      <= '0;
            clr_last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.state == imh_pkg::S_CLEAR)
            begin
                clr_reg      <= clr_reg + VW'(1);
                clr_last_reg <= (clr_reg == VW'(imh_pkg::CAPACITY - 1));
            end
            if (cmd.state == imh_pkg::S_CHECK && !st.reject)
            begin
                if (st.is_insert)
                    cnt_reg <= cnt_reg + SW'(1);
                else if (st.is_extract)
                    cnt_reg <= cnt_reg - SW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_req;
            vtx_reg <= in_vertex;
            key_reg <= in_key;
        end
        unique case (cmd.state)
            imh_pkg::S_CHECK:
            begin
                min_reg    <= '0;
                status_reg <= imh_pkg::ST_OK;
                ckey_reg   <= key_reg;
                cvtx_reg   <= vtx_reg;
                // presence follows the position map, whatever the limit
                present_reg <= (prd_data_reg != '0);
                if (st.reject)
                begin
                    unique case (req_reg)
                        imh_pkg::REQ_INSERT:
                            status_reg <= vtx_oor ? imh_pkg::ST_BADVERT :
                                          (cnt_reg >= lim_eff) ? imh_pkg::ST_FULL :
                                          imh_pkg::ST_BADVERT;
                        imh_pkg::REQ_EXTRACT: status_reg <= imh_pkg::ST_EMPTY;
                        default:              status_reg <= imh_pkg::ST_BADVERT;
                    endcase
                end
                else if (st.is_insert)
                begin
                    cur_reg     <= cnt_reg + SW'(1);
                    present_reg <= 1'b1;
                end
                else if (st.is_setkey)
                    cur_reg <= prd_data_reg;
            end
            imh_pkg::S_UP_CMP:
                if (ckey_reg < rkey)
                    cur_reg <= parent;
            imh_pkg::S_EX_RD:
            begin
                // rd_reg holds the root
                min_reg <= rd_reg[VW-1:0];
                cur_reg <= SW'(1);
                if (rd_reg[VW-1:0] == vtx_reg)
                    present_reg <= 1'b0;
            end
            imh_pkg::S_EX_MOVE:
            begin
                ckey_reg <= rd_reg[KW+VW-1:VW];
                cvtx_reg <= rd_reg[VW-1:0];
            end
            imh_pkg::S_DN_RD2:  lch_reg <= rd_reg;
            imh_pkg::S_DN_CMP:
                if (pick_l || pick_r)
                    cur_reg <= pick_r ? rchild[SW-1:0] : lchild[SW-1:0];
            default: ;
        endcase
    end

    assign res_status  = status_reg;
    assign res_min     = min_reg;
    assign res_present = present_reg;
    assign res_count   = imh_pkg::CNT_W'(cnt_reg);
endmodule

FILE: hdl/indexed_min_heap_decrease_key_core.sv
// one transaction in flight: a new request is taken only once the previous one is done
// reset: heap empties, limit returns to 256, then a clearing pass over
// the position map during which no request is taken
module indexed_min_heap_decrease_key_core (
    input  logic clk,
    input  logic rst_n,
    imh_req_if.sink   req,
    imh_rsp_if.source rsp,
    imh_cfg_if.sink   cfg
);
    imh_pkg::cmd_t  cmd;
    imh_pkg::stat_t st;

    logic [imh_pkg::CNT_W-1:0] limit_reg;
    logic                      rsp_valid_reg;
    logic                      in_fire;
    logic                      out_free;

    logic [1:0]                d_status;
    logic [imh_pkg::VERT_W-1:0] d_min;
    logic                      d_present;
    logic [imh_pkg::CNT_W-1:0] d_count;

    logic [1:0]                status_reg;
    logic [imh_pkg::VERT_W-1:0] min_reg;
    logic                      present_reg;
    logic [imh_pkg::CNT_W-1:0] count_reg;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= imh_pkg::CNT_W'(256);
        else if (cfg.valid)
            limit_reg <= cfg.data;
    end

    assign req.ready = (cmd.state == imh_pkg::S_IDLE);
    assign in_fire   = req.valid && req.ready;
    // output register frees when empty or being taken this cycle
    assign out_free  = !rsp_valid_reg || rsp.ready;

    imh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd)
    );

    imh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_req      (req.req_type),
        .in_vertex   (req.vertex),
        .in_key      (req.key),
        .limit       (limit_reg),
        .cmd         (cmd),
        .st          (st),
        .res_status  (d_status),
        .res_min     (d_min),
        .res_present (d_present),
        .res_count   (d_count)
    );

    // result register: loaded at the end of a transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.state == imh_pkg::S_DONE && out_free)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.state == imh_pkg::S_DONE && out_free)
        begin
            status_reg  <= d_status;
            min_reg     <= d_min;
            present_reg <= d_present;
            count_reg   <= d_count;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.min_vertex     = min_reg;
    assign rsp.vertex_present = present_reg;
    assign rsp.entry_count    = count_reg;
endmodule

FILE: hdl/imh_checker.sv
module imh_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [1:0] rsp_status,
    input logic [imh_pkg::VERT_W-1:0] rsp_min,
    input logic [imh_pkg::CNT_W-1:0] rsp_count
);
    // one transaction at a time: input closes right after a request is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready) else $error("second request taken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_min)
                                    && $stable(rsp_count))
        else $error("result changed while waiting");

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == imh_pkg::ST_EMPTY |-> rsp_min == '0 && rsp_count == '0)
        else $error("empty extract returned data");

    a_count_rng: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_count) <= imh_pkg::CAPACITY) else $error("count too large");
endmodule

bind indexed_min_heap_decrease_key_core imh_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_min    (rsp.min_vertex),
    .rsp_count  (rsp.entry_count)
);

FILE: dv/imh_tb_if.sv
// channel interfaces are provided by hdl/imh_if.sv; this file holds the
// testbench-side transaction types shared by the driver and the monitor
package imh_tb_pkg;

    typedef struct packed {
        imh_pkg::req_t  op;
        imh_pkg::vert_t vertex;
        imh_pkg::key_t  key;
    } heap_req_t;

    typedef struct packed {
        imh_pkg::status_t status;
        imh_pkg::vert_t   min_vertex;
        logic             vertex_present;
        logic [8:0]       entry_count;
    } heap_rsp_t;
endpackage

FILE: dv/indexed_min_heap_decrease_key_core_tb.sv
module indexed_min_heap_decrease_key_core_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    imh_req_if req_ch();
    imh_rsp_if rsp_ch();
    imh_cfg_if cfg_ch();

    indexed_min_heap_decrease_key_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // shadow heap state, updated as each request transaction is accepted
    imh_pkg::key_t  hk_key  [1:imh_pkg::CAPACITY];
    imh_pkg::vert_t hk_vert [1:imh_pkg::CAPACITY];
    logic [8:0] slot_of [0:imh_pkg::CAPACITY-1] = '{default: '0};
    logic [8:0] n_live = '0;
    logic [8:0] cap_reg = 9'd256;

    imh_tb_pkg::heap_req_t pending_reqs[$];
    imh_tb_pkg::heap_rsp_t expected_rsps[$];

    int  fail_count = 0;
    int  cycle = 0;
    int  idle_pct = 38;      // 0 gives a stretch with no idling
    bit  hold_rsp = 1'b0;    // long receiver hold-off
    bit  cfg_go = 1'b0;
    logic [8:0] cfg_value = '0;

    function automatic int lim_now();
        int l;
        l = cap_reg;
        if (l == 0) l = 1;
        if (l > imh_pkg::CAPACITY) l = imh_pkg::CAPACITY;
        return l;
    endfunction

    function automatic void swap_slots(int a, int b);
        imh_pkg::key_t  tk;
        imh_pkg::vert_t tv;
        tk = hk_key[a];
        tv = hk_vert[a];
        hk_key[a] = hk_key[b];
        hk_vert[a] = hk_vert[b];
        hk_key[b] = tk;
        hk_vert[b] = tv;
        slot_of[hk_vert[a]] = 9'(a);
        slot_of[hk_vert[b]] = 9'(b);
    endfunction

    function automatic void bubble_up(int s);
        while (s > 1 && hk_key[s] < hk_key[s/2]) begin
            swap_slots(s, s/2);
            s = s / 2;
        end
    endfunction

    function automatic void bubble_down(int s);
        int l, r, m;
        forever begin
            l = 2 * s;
            r = l + 1;
            m = s;
            if (l <= n_live && hk_key[l] < hk_key[m]) m = l;
            if (r <= n_live && hk_key[r] < hk_key[m]) m = r;
            if (m == s) break;
            swap_slots(s, m);
            s = m;
        end
    endfunction

    // apply one request to the shadow heap and return its expected response
    function automatic imh_tb_pkg::heap_rsp_t heap_apply(imh_tb_pkg::heap_req_t t);
        imh_tb_pkg::heap_rsp_t e;
        int lim, last, s;
        lim = lim_now();
        e = '0;
        e.status = imh_pkg::ST_OK;
        case (t.op)
            imh_pkg::REQ_INSERT:
            begin
                if (t.vertex >= lim) e.status = imh_pkg::ST_BADVERT;
                else if (n_live >= lim) e.status = imh_pkg::ST_FULL;
                else if (slot_of[t.vertex] != 0) e.status = imh_pkg::ST_BADVERT;
                else
                begin
                    n_live = n_live + 1;
                    hk_key[n_live] = t.key;
                    hk_vert[n_live] = t.vertex;
                    slot_of[t.vertex] = n_live;
                    bubble_up(n_live);
                end
            end
            imh_pkg::REQ_EXTRACT:
            begin
                if (n_live == 0) e.status = imh_pkg::ST_EMPTY;
                else
                begin
                    last = n_live;
                    e.min_vertex = hk_vert[1];
                    slot_of[hk_vert[1]] = 0;
                    n_live = n_live - 1;
                    if (n_live > 0)
                    begin
                        hk_key[1] = hk_key[last];
                        hk_vert[1] = hk_vert[last];
                        slot_of[hk_vert[1]] = 1;
                        bubble_down(1);
                    end
                end
            end
            imh_pkg::REQ_SETKEY:
            begin
                if (t.vertex >= lim || slot_of[t.vertex] == 0)
                    e.status = imh_pkg::ST_BADVERT;
                else
                begin
                    s = slot_of[t.vertex];
                    hk_key[s] = t.key;
                    bubble_up(s);
                end
            end
            default: ;
        endcase
        e.vertex_present = (slot_of[t.vertex] != 0);
        e.entry_count = n_live;
        return e;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= imh_pkg::REQ_NONE;
            req_ch.vertex <= '0;
            req_ch.key <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(heap_apply(pending_reqs.pop_front()));
            end
            if ((!req_ch.valid || req_ch.ready) && pending_reqs.size() > 0
                && $urandom_range(99) >= idle_pct)
            begin
                req_ch.valid <= 1'b1;
                req_ch.req_type <= pending_reqs[0].op;
                req_ch.vertex <= pending_reqs[0].vertex;
                req_ch.key <= pending_reqs[0].key;
            end
            else if (req_ch.ready)
                req_ch.valid <= 1'b0;
        end
    end

    // response monitor and ready generator
    always @(posedge clk or negedge rst_n)
    begin
        imh_tb_pkg::heap_rsp_t exp_r;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp_ch.status !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d", exp_r.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.min_vertex !== exp_r.min_vertex)
                    begin
                        $error("min_vertex expected %0d actual %0d",
                               exp_r.min_vertex, rsp_ch.min_vertex);
                        fail_count++;
                    end
                    if (rsp_ch.vertex_present !== exp_r.vertex_present)
                    begin
                        $error("vertex_present expected %0d actual %0d",
                               exp_r.vertex_present, rsp_ch.vertex_present);
                        fail_count++;
                    end
                    if (rsp_ch.entry_count !== exp_r.entry_count)
                    begin
                        $error("entry_count expected %0d actual %0d",
                               exp_r.entry_count, rsp_ch.entry_count);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
        end
    end

    // config writer: holds valid until the register takes the transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.data <= '0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            cfg_ch.valid <= 1'b0;
            cap_reg <= cfg_ch.data;
        end
        else if (cfg_go && !cfg_ch.valid)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data <= cfg_value;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 400000)
        begin
            $display("indexed_min_heap_decrease_key_core: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_limit(logic [8:0] v);
        cfg_value = v;
        cfg_go = 1'b1;
        @(posedge clk iff (cfg_ch.valid && cfg_ch.ready));
        cfg_go = 1'b0;
    endtask

    task automatic add_req(imh_pkg::req_t op, int v, imh_pkg::key_t k);
        imh_tb_pkg::heap_req_t t;
        t.op = op;
        t.vertex = 8'(v);
        t.key = k;
        pending_reqs.push_back(t);
    endtask

    // mostly well-formed traffic over vertices below vrange, which may exceed the limit
    task automatic random_phase(int count, int vrange);
        int r;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 45) add_req(imh_pkg::REQ_INSERT, $urandom_range(vrange - 1),
                                ($urandom_range(3) == 0) ? $urandom : $urandom_range(64));
            else if (r < 75) add_req(imh_pkg::REQ_EXTRACT, $urandom_range(255), $urandom);
            else if (r < 95) add_req(imh_pkg::REQ_SETKEY, $urandom_range(vrange - 1),
                                     ($urandom_range(1) == 0) ? $urandom : $urandom_range(64));
            else add_req(imh_pkg::req_t'($urandom_range(3)), $urandom_range(255), $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty extract, extremes, duplicates, absent set-key, no-op
        add_req(imh_pkg::REQ_EXTRACT, 0, 0);
        add_req(imh_pkg::REQ_SETKEY, 5, 1);
        add_req(imh_pkg::REQ_INSERT, 255, 32'hFFFF_FFFF);
        add_req(imh_pkg::REQ_INSERT, 0, 32'h0);
        add_req(imh_pkg::REQ_INSERT, 0, 7);
        add_req(imh_pkg::REQ_INSERT, 170, 32'h5555_5555);
        add_req(imh_pkg::REQ_INSERT, 85, 32'hAAAA_AAAA);
        add_req(imh_pkg::REQ_SETKEY, 255, 1);
        add_req(imh_pkg::REQ_SETKEY, 85, 32'hFFFF_FFFF);
        add_req(imh_pkg::REQ_NONE, 255, 32'hFFFF_FFFF);
        add_req(imh_pkg::REQ_EXTRACT, 3, 0);
        add_req(imh_pkg::REQ_EXTRACT, 0, 0);
        add_req(imh_pkg::REQ_EXTRACT, 0, 0);
        add_req(imh_pkg::REQ_EXTRACT, 0, 0);
        add_req(imh_pkg::REQ_EXTRACT, 0, 0);
        wait_drained();

        // limit 1: out-of-range vertex, full
        set_limit(9'd1);
        add_req(imh_pkg::REQ_INSERT, 1, 3);
        add_req(imh_pkg::REQ_INSERT, 0, 3);
        add_req(imh_pkg::REQ_INSERT, 0, 4);
        add_req(imh_pkg::REQ_SETKEY, 1, 0);
        wait_drained();

        // limit 0 behaves as 1, entries stay
        set_limit(9'd0);
        add_req(imh_pkg::REQ_EXTRACT, 0, 0);
        add_req(imh_pkg::REQ_INSERT, 0, 9);
        wait_drained();

        // limit above capacity, burst under a long receiver hold-off
        set_limit(9'd511);
        idle_pct = 0;
        random_phase(60, 256);
        hold_rsp = 1'b1;
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
        wait_drained();
        idle_pct = 38;

        // small limit with existing entries above it
        set_limit(9'd8);
        random_phase(80, 12);
        wait_drained();

        set_limit(9'd256);
        random_phase(140, 256);
        wait_drained();

        set_limit(9'd16);
        random_phase(100, 20);
        wait_drained();

        if (fail_count == 0)
            $display("indexed_min_heap_decrease_key_core: match");
        else
            $display("indexed_min_heap_decrease_key_core: mismatch");
        $finish;
    end
endmodule
